/* rtl/ipf_pkg.sv */
// ipf_pkg: shared types and constants for the ipv4 port rule filter
// used by ipf_ctrl, ipf_datapath and ipv4_port_rule_filter; no dependencies
package ipf_pkg;

   localparam int RULE_COUNT = 16;
   localparam int RULE_IDX_W = (RULE_COUNT > 1) ? $clog2(RULE_COUNT) : 1;

   localparam int  HIT_W       = 4;
   localparam int  COUNT_W     = 7;
   localparam logic [COUNT_W-1:0] COUNT_MAX   = 7'd127;
   localparam logic [COUNT_W-1:0] MIN_LEN     = 7'd20;
   localparam logic [COUNT_W-1:0] PROTO_POS   = 7'd9;
   localparam logic [3:0]         IPV4_VER    = 4'd4;
   localparam logic [7:0]         PROTO_TCP   = 8'd6;
   localparam logic [7:0]         PROTO_UDP   = 8'd17;

   localparam logic OP_RULE_WRITE = 1'b0;
   localparam logic OP_PACKET_BYTE = 1'b1;

   localparam logic ACTION_ALLOW = 1'b0;

   typedef struct packed {
      logic        operation;
      logic [3:0]  rule_index;
      logic        rule_enabled;
      logic        rule_action;
      logic [7:0]  rule_protocol;
      logic [15:0] rule_port_low;
      logic [15:0] rule_port_high;
      logic [63:0] peer;
      logic [1:0]  direction;
      logic [7:0]  data_byte;
      logic        last_byte;
   } req_type;

   typedef struct packed {
      logic             verdict_allow;
      logic             rule_hit;
      logic [HIT_W-1:0] hit_index;
   } rsp_type;

   typedef struct packed {
      logic        action;
      logic [1:0]  direction;
      logic [7:0]  protocol;
      logic [15:0] port_low;
      logic [15:0] port_high;
   } rule_attr_type;

   // controller to datapath
   typedef struct packed {
      logic write_rule;
      logic take_byte;
      logic scan_start;
      logic scan_step;
      logic finish;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic bypass;
      logic rule_match;
      logic scan_end;
   } status_type;

endpackage

/* rtl/ipf_ctrl.sv */
// ipf_ctrl: state machine that sequences rule writes, byte capture, the rule scan and the result
// depends on ipf_pkg
module ipf_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                operation,
   input  logic                last_byte,
   input  ipf_pkg::status_type status,
   output ipf_pkg::cmd_type    cmd,
   output logic                busy,
   output logic                rsp_strobe
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      accepted;
   logic      scan_over;

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = (state_ff == ST_DONE);
   assign accepted   = start && !busy;
   assign scan_over  = status.bypass || status.rule_match || status.scan_end;

   always_comb begin
      state_in        = state_ff;
      cmd             = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accepted) begin
               if (operation == ipf_pkg::OP_RULE_WRITE) begin
                  cmd.write_rule = 1'b1;
               end else begin
                  cmd.take_byte = 1'b1;
                  if (last_byte) begin
                     cmd.scan_start = 1'b1;
                     state_in       = ST_SCAN;
                  end
               end
            end
         end
         ST_SCAN: begin
            if (scan_over) begin
               cmd.finish = 1'b1;
               state_in   = ST_DONE;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_last_starts_scan: assert property (@(posedge clock) disable iff (reset)
      accepted && operation == ipf_pkg::OP_PACKET_BYTE && last_byte |=> state_ff == ST_SCAN)
      else $error("last byte did not start a rule scan");

   a_finish_gives_word: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_strobe)
      else $error("scan finished without a result word");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe && !busy)
      else $error("result strobe held longer than one cycle");

   a_scan_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(cmd.finish && cmd.scan_step) && !(cmd.take_byte && cmd.scan_step))
      else $error("conflicting datapath commands");

endmodule

/* rtl/ipf_datapath.sv */
// ipf_datapath: rule table, packet byte capture and the one-rule-per-cycle match unit
// depends on ipf_pkg
module ipf_datapath (
   input  logic                clock,
   input  logic                reset,
   input  ipf_pkg::req_type    req_data,
   input  ipf_pkg::cmd_type    cmd,
   output ipf_pkg::status_type status,
   output ipf_pkg::rsp_type    rsp_data
);

   // rule table: enable bits reset, the rest is only looked at when enabled
   logic [ipf_pkg::RULE_COUNT-1:0]  rule_en_ff;
   ipf_pkg::rule_attr_type          rule_attr_ff [ipf_pkg::RULE_COUNT];
   logic [63:0]                     rule_peer_ff [ipf_pkg::RULE_COUNT];

   logic [ipf_pkg::COUNT_W-1:0]     byte_count_ff;
   logic [7:0]                      version_ff;
   logic [7:0]                      proto_ff;
   logic [7:0]                      port_hi_ff;
   logic [7:0]                      port_lo_ff;

   logic [63:0]                     pkt_peer_ff;
   logic [1:0]                      pkt_dir_ff;
   logic [ipf_pkg::RULE_IDX_W-1:0]  scan_idx_ff;
   ipf_pkg::rsp_type                rsp_ff;

   logic                            index_ok;
   logic [ipf_pkg::RULE_IDX_W-1:0]  wr_idx;
   logic [ipf_pkg::COUNT_W-1:0]     ihl;
   logic [ipf_pkg::COUNT_W-1:0]     pos;
   logic                            has_port;
   logic [15:0]                     dport;
   ipf_pkg::rule_attr_type          cur_attr;
   logic [63:0]                     cur_peer;
   logic                            cur_en;
   logic                            port_ok;

   assign index_ok = (32'(req_data.rule_index) < ipf_pkg::RULE_COUNT);
   assign wr_idx   = ipf_pkg::RULE_IDX_W'(req_data.rule_index);

   always_ff @(posedge clock) begin
      if (reset) begin
         rule_en_ff <= '0;
      end else if (cmd.write_rule && index_ok) begin
         rule_en_ff[wr_idx] <= req_data.rule_enabled;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write_rule && index_ok) begin
         rule_attr_ff[wr_idx] <= '{action:    req_data.rule_action,
                                   direction: req_data.direction,
                                   protocol:  req_data.rule_protocol,
                                   port_low:  req_data.rule_port_low,
                                   port_high: req_data.rule_port_high};
         rule_peer_ff[wr_idx] <= req_data.peer;
      end
   end

   // byte capture; ihl comes from the stored first byte
   assign pos = byte_count_ff;
   assign ihl = {1'b0, version_ff[3:0], 2'b00};

   always_ff @(posedge clock) begin
      if (reset || cmd.finish) begin
         byte_count_ff <= '0;
         version_ff    <= '0;
         proto_ff      <= '0;
         port_hi_ff    <= '0;
         port_lo_ff    <= '0;
      end else if (cmd.take_byte) begin
         if (byte_count_ff != ipf_pkg::COUNT_MAX) begin
            byte_count_ff <= byte_count_ff + 1'b1;
         end
         if (pos == '0) begin
            version_ff <= req_data.data_byte;
         end
         if (pos == ipf_pkg::PROTO_POS) begin
            proto_ff <= req_data.data_byte;
         end
         if (pos != '0 && pos == ihl + 7'd2) begin
            port_hi_ff <= req_data.data_byte;
         end
         if (pos != '0 && pos == ihl + 7'd3) begin
            port_lo_ff <= req_data.data_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_start) begin
         pkt_peer_ff <= req_data.peer;
         pkt_dir_ff  <= req_data.direction;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_start) begin
         scan_idx_ff <= '0;
      end else if (cmd.scan_step) begin
         scan_idx_ff <= scan_idx_ff + 1'b1;
      end
   end

   // match unit for the rule under the scan index
   assign has_port = (proto_ff == ipf_pkg::PROTO_TCP || proto_ff == ipf_pkg::PROTO_UDP)
                     && (byte_count_ff >= ihl + 7'd4);
   assign dport    = {port_hi_ff, port_lo_ff};
   assign cur_attr = rule_attr_ff[scan_idx_ff];
   assign cur_peer = rule_peer_ff[scan_idx_ff];
   assign cur_en   = rule_en_ff[scan_idx_ff];
   assign port_ok  = (cur_attr.port_high == '0)
                     || (has_port && dport >= cur_attr.port_low
                                  && dport <= cur_attr.port_high);

   assign status.bypass     = (byte_count_ff < ipf_pkg::MIN_LEN)
                              || (version_ff[7:4] != ipf_pkg::IPV4_VER);
   assign status.rule_match = cur_en
                              && (cur_attr.direction == '0 || cur_attr.direction == pkt_dir_ff)
                              && (cur_peer == '0 || cur_peer == pkt_peer_ff)
                              && (cur_attr.protocol == '0 || cur_attr.protocol == proto_ff)
                              && port_ok;
   assign status.scan_end   = (scan_idx_ff == ipf_pkg::RULE_IDX_W'(ipf_pkg::RULE_COUNT - 1));

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         priority if (status.bypass || !status.rule_match) begin
            rsp_ff <= '{verdict_allow: 1'b1, rule_hit: 1'b0, hit_index: '0};
         end else begin
            rsp_ff <= '{verdict_allow: (cur_attr.action == ipf_pkg::ACTION_ALLOW),
                        rule_hit:      1'b1,
                        hit_index:     ipf_pkg::HIT_W'(scan_idx_ff)};
         end
      end
   end

   assign rsp_data = rsp_ff;

   a_bypass_no_hit: assert property (@(posedge clock) disable iff (reset)
      cmd.finish && status.bypass |=> rsp_ff.rule_hit == 1'b0 && rsp_ff.verdict_allow)
      else $error("bypassed packet reported a rule hit");

   a_count_saturates: assert property (@(posedge clock) disable iff (reset)
      cmd.take_byte && !cmd.finish && byte_count_ff == ipf_pkg::COUNT_MAX
      |=> byte_count_ff == ipf_pkg::COUNT_MAX)
      else $error("byte count wrapped");

   a_finish_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> byte_count_ff == '0 && version_ff == '0)
      else $error("packet capture not cleared after the result");

endmodule

/* rtl/ipv4_port_rule_filter.sv */
// ipv4_port_rule_filter: top level of the first-match ipv4 port rule filter
// depends on ipf_pkg, ipf_ctrl and ipf_datapath
//
// use: a request word is taken at a rising edge with start high and busy low.
// req_data.operation picks a rule write (table slot rule_index, peer and
// direction fields give the rule's peer and direction) or one packet byte.
// rule writes and packet bytes that are not the last never raise busy. the
// last byte of a packet starts a rule scan that visits one rule per cycle in
// index order, stopping at the first match or after the last rule (at once
// for short or non-ipv4 packets); the result word is registered as it ends
// and shown in the done state, and busy stays high until the cycle after it.
// rsp_strobe is high for exactly one cycle, and rsp_data keeps the result
// word until the next one; the receiver cannot hold it off. the scan over the
// stored rules sets the packet-end latency, one rule compare per clock.
// reset (synchronous, active high) disables every rule and clears the packet
// capture; the block is ready in the cycle after reset falls.
module ipv4_port_rule_filter (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  ipf_pkg::req_type req_data,
   output logic             busy,
   output logic             rsp_strobe,
   output ipf_pkg::rsp_type rsp_data
);

   ipf_pkg::cmd_type    cmd;
   ipf_pkg::status_type status;

   ipf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .operation  (req_data.operation),
      .last_byte  (req_data.last_byte),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   ipf_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule
